// File: rtl/gb3_pkg.sv
package gb3_pkg;

   // Line store geometry
   localparam int MAX_WIDTH = 2048;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int EFF_W     = ADDR_W + 1;

   // Field and register widths
   localparam int PIXEL_W      = 8;
   localparam int ROW_W        = 16;
   localparam int COL_W        = ADDR_W;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int SUM_W        = PIXEL_W + 4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = HEIGHT_REG_W'(480);

   // Response queue
   localparam int MAX_RESULTS = 4;
   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int PUSH_CNT_W  = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [PIXEL_W-1:0] value;
      logic               frame_done;
   } result_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] two_above;
      logic [PIXEL_W-1:0] above;
   } line_word_type;

   // window[y][x], y = 0 is the oldest row, x = 2 the newest column
   typedef logic [2:0][2:0][PIXEL_W-1:0] window_type;

   // Binomial 3x3 sum around (cr, cc), absent neighbors skipped, floored by 16.
   function automatic logic [PIXEL_W-1:0] blur_at(window_type win, int cr, int cc,
                                                   logic up, logic dn, logic lf,
                                                   logic rt);
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] term;
      logic             take;
      sum = '0;
      for (int ky = 0; ky < 3; ky++) begin
         for (int kx = 0; kx < 3; kx++) begin
            take = (ky >= cr - 1) && (ky <= cr + 1) && (kx >= cc - 1) && (kx <= cc + 1);
            if (ky < cr && !up) take = 1'b0;
            if (ky > cr && !dn) take = 1'b0;
            if (kx < cc && !lf) take = 1'b0;
            if (kx > cc && !rt) take = 1'b0;
            term = SUM_W'(win[ky][kx]);
            if (ky == cr) term = term << 1;
            if (kx == cc) term = term << 1;
            if (take) sum = sum + term;
         end
      end
      return sum[SUM_W-1:4];
   endfunction

endpackage

// File: rtl/gb3_rsp_fifo.sv
module gb3_rsp_fifo (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic [gb3_pkg::MAX_RESULTS-1:0]                 push_en,
   input  gb3_pkg::result_type [gb3_pkg::MAX_RESULTS-1:0] push_data,
   input  logic                                            pop,
   output gb3_pkg::result_type                             head,
   output logic [gb3_pkg::FIFO_PTR_W:0]                    count
);

   gb3_pkg::result_type entries [gb3_pkg::FIFO_DEPTH];

   logic [gb3_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gb3_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gb3_pkg::FIFO_PTR_W:0]   count_ff, count_in;
   logic [gb3_pkg::FIFO_PTR_W-1:0] slot [gb3_pkg::MAX_RESULTS];
   logic [gb3_pkg::PUSH_CNT_W-1:0] n_push;

   // Results that are present are packed into consecutive slots, in order.
   always_comb begin
      n_push = '0;
      for (int i = 0; i < gb3_pkg::MAX_RESULTS; i++) begin
         slot[i] = wr_ptr_ff + gb3_pkg::FIFO_PTR_W'(n_push);
         if (push_en[i]) n_push = n_push + gb3_pkg::PUSH_CNT_W'(1);
      end
      wr_ptr_in = wr_ptr_ff + gb3_pkg::FIFO_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + gb3_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + (gb3_pkg::FIFO_PTR_W + 1)'(n_push)
                  - (gb3_pkg::FIFO_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < gb3_pkg::MAX_RESULTS; i++) begin
         if (push_en[i]) entries[slot[i]] <= push_data[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = entries[rd_ptr_ff];
   assign count = count_ff;

endmodule

// File: rtl/gaussian_blur_3x3_stream.sv
// Streaming 3x3 binomial blur: one pixel request per clock. The input stalls only while
// the response queue may lack room for four more results, as on the last row of a frame
// (two results or more per request) or while responses are held off.
// A result leaves at the earliest after the request completing its window has passed
// stage 1 and the queue; the line store is read at acceptance and written back in stage 1.
// Synchronous active-high reset clears counters, window, queue, registers (640x480).
module gaussian_blur_3x3_stream (
   input  logic                                clock,
   input  logic                                reset,
   // Pixel requests
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gb3_pkg::PIXEL_W-1:0]         req_pixel_in,
   // Filtered responses
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gb3_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [gb3_pkg::COL_W-1:0]           rsp_out_col,
   output logic [gb3_pkg::PIXEL_W-1:0]         rsp_out_value,
   output logic                                rsp_frame_done,
   // Configuration writes
   input  logic                                csr_write_enable,
   input  logic [gb3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gb3_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // ---------------------------------------------------------------------------
   // Configuration registers. Any write to a known register restarts the frame.
   // ---------------------------------------------------------------------------
   logic [gb3_pkg::WIDTH_REG_W-1:0]  image_width_ff, image_width_in;
   logic [gb3_pkg::HEIGHT_REG_W-1:0] image_height_ff, image_height_in;
   logic                             csr_restart;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      csr_restart     = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            gb3_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_write_data[gb3_pkg::WIDTH_REG_W-1:0];
               csr_restart    = 1'b1;
            end
            gb3_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_write_data[gb3_pkg::HEIGHT_REG_W-1:0];
               csr_restart     = 1'b1;
            end
            default: begin
               csr_restart = 1'b0;
            end
         endcase
      end
   end

   // Effective frame size: width clamped to 1..MAX_WIDTH, height zero taken as one.
   logic [gb3_pkg::EFF_W-1:0]        width_eff;
   logic [gb3_pkg::HEIGHT_REG_W-1:0] height_eff;

   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = gb3_pkg::EFF_W'(1);
      end else if (32'(image_width_ff) > 32'(gb3_pkg::MAX_WIDTH)) begin
         width_eff = gb3_pkg::EFF_W'(gb3_pkg::MAX_WIDTH);
      end else begin
         width_eff = gb3_pkg::EFF_W'(image_width_ff);
      end
      height_eff = (image_height_ff == '0) ? gb3_pkg::HEIGHT_REG_W'(1) : image_height_ff;
   end

   // ---------------------------------------------------------------------------
   // Stage 0: accept a request, advance the raster position and issue the line
   // store read at the current column.
   // ---------------------------------------------------------------------------
   logic                       req_accept;
   logic [gb3_pkg::COL_W-1:0]  col_count_ff, col_count_in;
   logic [gb3_pkg::ROW_W-1:0]  row_count_ff, row_count_in;
   logic                       row_end;
   logic                       last_row;

   assign req_accept = req_valid && !req_stall;
   assign row_end    = ({1'b0, col_count_ff} + gb3_pkg::EFF_W'(1)) >= width_eff;
   assign last_row   = ({1'b0, row_count_ff} + (gb3_pkg::ROW_W + 1)'(1))
                       >= {1'b0, height_eff};

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (csr_restart) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (req_accept) begin
         if (row_end) begin
            col_count_in = '0;
            row_count_in = last_row ? '0 : row_count_ff + gb3_pkg::ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + gb3_pkg::COL_W'(1);
         end
      end
   end

   // Stage 1 context of the accepted request.
   logic                         s1_valid_ff, s1_valid_in;
   logic [gb3_pkg::COL_W-1:0]    s1_col_ff;
   logic [gb3_pkg::ROW_W-1:0]    s1_row_ff;
   logic                         s1_row_end_ff;
   logic                         s1_last_row_ff;
   logic [gb3_pkg::PIXEL_W-1:0]  s1_pixel_ff;

   assign s1_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= gb3_pkg::RESET_WIDTH;
         image_height_ff <= gb3_pkg::RESET_HEIGHT;
         col_count_ff    <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_count_ff    <= col_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff      <= col_count_ff;
         s1_row_ff      <= row_count_ff;
         s1_row_end_ff  <= row_end;
         s1_last_row_ff <= last_row;
         s1_pixel_ff    <= req_pixel_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Line store: one word per column holding the pixels of the two rows above.
   // Read at acceptance, written back in stage 1. The read and the previous
   // request's write can hit the same column in the same cycle (a one-pixel
   // row), so the last write is kept in a bypass register and wins on an
   // address match.
   // ---------------------------------------------------------------------------
   gb3_pkg::line_word_type line_mem [gb3_pkg::MAX_WIDTH];
   gb3_pkg::line_word_type mem_rd_ff;
   gb3_pkg::line_word_type line_rd;
   gb3_pkg::line_word_type line_wr;

   logic                         byp_valid_ff, byp_valid_in;
   logic [gb3_pkg::ADDR_W-1:0]   byp_addr_ff, byp_addr_in;
   gb3_pkg::line_word_type       byp_data_ff, byp_data_in;

   always_ff @(posedge clock) begin
      if (req_accept) mem_rd_ff <= line_mem[col_count_ff];
      if (s1_valid_ff) line_mem[s1_col_ff] <= line_wr;
   end

   assign line_rd = (byp_valid_ff && byp_addr_ff == s1_col_ff) ? byp_data_ff : mem_rd_ff;

   always_comb begin
      line_wr.two_above = line_rd.above;
      line_wr.above     = s1_pixel_ff;
      byp_valid_in      = byp_valid_ff || s1_valid_ff;
      byp_addr_in       = s1_valid_ff ? s1_col_ff : byp_addr_ff;
      byp_data_in       = s1_valid_ff ? line_wr : byp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= byp_valid_in;
      end
      byp_addr_ff <= byp_addr_in;
      byp_data_ff <= byp_data_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 1: shift the window, form up to four results and queue them.
   // Result 0 is one row and one column back, result 1 the row end of the row
   // above, results 2 and 3 the same for the last row of the frame.
   // ---------------------------------------------------------------------------
   gb3_pkg::window_type window_ff, window_in;

   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int y = 0; y < 3; y++) begin
            window_in[y][0] = window_ff[y][1];
            window_in[y][1] = window_ff[y][2];
         end
         window_in[0][2] = line_rd.two_above;
         window_in[1][2] = line_rd.above;
         window_in[2][2] = s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   logic                                            r_ge1, r_ge2, c_ge1, c_ge2;
   logic [gb3_pkg::MAX_RESULTS-1:0]                 push_en;
   gb3_pkg::result_type [gb3_pkg::MAX_RESULTS-1:0] push_data;
   logic [gb3_pkg::ROW_W-1:0]                       row_prev;
   logic [gb3_pkg::COL_W-1:0]                       col_prev;

   always_comb begin
      r_ge1    = s1_row_ff != '0;
      r_ge2    = s1_row_ff > gb3_pkg::ROW_W'(1);
      c_ge1    = s1_col_ff != '0;
      c_ge2    = s1_col_ff > gb3_pkg::COL_W'(1);
      row_prev = s1_row_ff - gb3_pkg::ROW_W'(1);
      col_prev = s1_col_ff - gb3_pkg::COL_W'(1);

      push_en[0] = s1_valid_ff && r_ge1 && c_ge1;
      push_en[1] = s1_valid_ff && r_ge1 && s1_row_end_ff;
      push_en[2] = s1_valid_ff && s1_last_row_ff && c_ge1;
      push_en[3] = s1_valid_ff && s1_last_row_ff && s1_row_end_ff;

      push_data[0].row        = row_prev;
      push_data[0].col        = col_prev;
      push_data[0].value      = gb3_pkg::blur_at(window_in, 1, 1, r_ge2, 1'b1, c_ge2, 1'b1);
      push_data[0].frame_done = 1'b0;

      push_data[1].row        = row_prev;
      push_data[1].col        = s1_col_ff;
      push_data[1].value      = gb3_pkg::blur_at(window_in, 1, 2, r_ge2, 1'b1, c_ge1, 1'b0);
      push_data[1].frame_done = 1'b0;

      push_data[2].row        = s1_row_ff;
      push_data[2].col        = col_prev;
      push_data[2].value      = gb3_pkg::blur_at(window_in, 2, 1, r_ge1, 1'b0, c_ge2, 1'b1);
      push_data[2].frame_done = 1'b0;

      // The frame's final pixel always produces this result, and it is the last one.
      push_data[3].row        = s1_row_ff;
      push_data[3].col        = s1_col_ff;
      push_data[3].value      = gb3_pkg::blur_at(window_in, 2, 2, r_ge1, 1'b0, c_ge1, 1'b0);
      push_data[3].frame_done = 1'b1;
   end

   // ---------------------------------------------------------------------------
   // Response queue. A request is taken only when the queue is sure to have
   // room for its results and for those of the request still in stage 1.
   // ---------------------------------------------------------------------------
   localparam int OCC_W = gb3_pkg::FIFO_PTR_W + 2;

   gb3_pkg::result_type              rsp_head;
   logic [gb3_pkg::FIFO_PTR_W:0]     fifo_count;
   logic [OCC_W-1:0]                 occupancy;
   logic                             rsp_pop;

   assign rsp_pop = rsp_valid && !rsp_stall;

   gb3_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .count     (fifo_count)
   );

   assign occupancy = OCC_W'(fifo_count)
                      + (s1_valid_ff ? OCC_W'(gb3_pkg::MAX_RESULTS) : OCC_W'(0));
   assign req_stall = occupancy > OCC_W'(gb3_pkg::FIFO_DEPTH - gb3_pkg::MAX_RESULTS);

   assign rsp_valid      = fifo_count != '0;
   assign rsp_out_row    = rsp_head.row;
   assign rsp_out_col    = rsp_head.col;
   assign rsp_out_value  = rsp_head.value;
   assign rsp_frame_done = rsp_head.frame_done;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= (gb3_pkg::FIFO_PTR_W + 1)'(gb3_pkg::FIFO_DEPTH))
      else $error("response queue overflow");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_count_ff} < width_eff)
      else $error("column counter beyond the row width");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && row_end && last_row && !csr_write_enable)
      |=> (col_count_ff == '0 && row_count_ff == '0))
      else $error("raster position did not wrap at the end of the frame");

endmodule
